>>> rtl/ilist_pkg.sv
package ilist_pkg;

	localparam int KIND_W   = 2;
	localparam int POS_W    = 7;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;
	localparam int TDATA_W  = 48;

	localparam int KIND_LSB   = 0;
	localparam int POS_LSB    = KIND_LSB + KIND_W;
	localparam int VAL_LSB    = POS_LSB + POS_W;
	localparam int REM_LSB    = 0;
	localparam int STATUS_LSB = REM_LSB + VAL_W;
	localparam int COUNT_LSB  = STATUS_LSB + STATUS_W;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic place;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic go_shift;
		logic busy;
		logic out_free;
	} stat_t;

endpackage

>>> rtl/ilist_ram.sv
module ilist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/ilist_ctrl.sv
module ilist_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  ilist_pkg::stat_t stat,
	output ilist_pkg::cmd_t  cmd
);
	import ilist_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = stat.go_shift ? ST_SHIFT : ST_FINISH;
				end
			end
			ST_SHIFT: begin
				cmd.step = 1'b1;
				if (!stat.busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.place = 1'b1;
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == ST_IDLE)
		else $error("load outside idle");

	a_commit_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> state_q == ST_IDLE)
		else $error("commit did not return to idle");

endmodule

>>> rtl/ilist_dp.sv
module ilist_dp #(
	parameter int CAPACITY = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ilist_pkg::TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ilist_pkg::TDATA_W-1:0] m_tdata,
	input  ilist_pkg::cmd_t               cmd,
	output ilist_pkg::stat_t              stat
);
	import ilist_pkg::*;

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	logic [KIND_W-1:0]   in_kind;
	logic [POS_W-1:0]    in_pos;
	logic [VAL_W-1:0]    in_val;
	logic [CMPW-1:0]     pos_x, cnt_x, cap_x;

	logic [STATUS_W-1:0] ld_status;
	logic [CW-1:0]       ld_cnt;
	logic                ld_ins, ld_del;

	logic [CW-1:0]       cnt_q, next_cnt_q;
	logic [STATUS_W-1:0] status_q;
	logic [AW-1:0]       pos_q, rd_ptr_q;
	logic [VAL_W-1:0]    val_q, removed_q;
	logic                ins_ok_q, is_del_q, first_q;
	logic [CW-1:0]       left_q;

	logic                pend_s1, first_s1;
	logic [AW-1:0]       wa_s1;

	logic                out_valid_q;
	logic [VAL_W-1:0]    out_rem_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [COUNT_W-1:0]  out_cnt_q;

	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_waddr;
	logic [VAL_W-1:0]    ram_wdata, ram_rdata;

	assign in_kind = s_tdata[KIND_LSB +: KIND_W];
	assign in_pos  = s_tdata[POS_LSB +: POS_W];
	assign in_val  = s_tdata[VAL_LSB +: VAL_W];
	assign pos_x   = CMPW'(in_pos);
	assign cnt_x   = CMPW'(cnt_q);
	assign cap_x   = CMPW'(CAPACITY);

	always_comb begin
		ld_status = STATUS_OK;
		ld_cnt    = cnt_q;
		ld_ins    = 1'b0;
		ld_del    = 1'b0;
		unique case (in_kind)
			KIND_INSERT: begin
				if (pos_x > cnt_x) begin
					ld_status = STATUS_RANGE;
				end else if (cnt_x == cap_x) begin
					ld_status = STATUS_FULL;
				end else begin
					ld_ins = 1'b1;
					ld_cnt = cnt_q + CW'(1);
				end
			end
			KIND_DELETE: begin
				if (pos_x >= cnt_x) begin
					ld_status = STATUS_RANGE;
				end else begin
					ld_del = 1'b1;
					ld_cnt = cnt_q - CW'(1);
				end
			end
			KIND_CLEAR: begin
				ld_cnt = '0;
			end
			default: begin
			end
		endcase
	end

	assign ram_re    = cmd.step && (left_q != '0);
	assign ram_we    = (pend_s1 && !first_s1) || (cmd.place && ins_ok_q && !pend_s1);
	assign ram_waddr = pend_s1 ? wa_s1 : pos_q;
	assign ram_wdata = pend_s1 ? ram_rdata : val_q;

	ilist_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q      <= AW'(in_pos);
			val_q      <= in_val;
			status_q   <= ld_status;
			next_cnt_q <= ld_cnt;
			is_del_q   <= ld_del;
			removed_q  <= '0;
			rd_ptr_q   <= ld_del ? AW'(in_pos) : AW'(cnt_q - CW'(1));
		end else begin
			if (ram_re) begin
				rd_ptr_q <= is_del_q ? rd_ptr_q + AW'(1) : rd_ptr_q - AW'(1);
			end
			if (pend_s1 && first_s1) begin
				removed_q <= ram_rdata;
			end
		end
		wa_s1    <= is_del_q ? rd_ptr_q - AW'(1) : rd_ptr_q + AW'(1);
		first_s1 <= first_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ins_ok_q    <= 1'b0;
			first_q     <= 1'b0;
			left_q      <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= ram_re;
			if (cmd.load) begin
				ins_ok_q <= ld_ins;
				first_q  <= ld_del;
				left_q   <= (ld_ins || ld_del) ? CW'(cnt_x - pos_x) : '0;
			end else if (ram_re) begin
				left_q  <= left_q - CW'(1);
				first_q <= 1'b0;
			end
			if (cmd.commit) begin
				cnt_q       <= next_cnt_q;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_rem_q    <= (pend_s1 && first_s1) ? ram_rdata : removed_q;
			out_status_q <= status_q;
			out_cnt_q    <= COUNT_W'(next_cnt_q);
		end
	end

	assign stat.go_shift = ld_ins || ld_del;
	assign stat.busy     = (left_q != '0) || pend_s1;
	assign stat.out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	always_comb begin
		m_tdata = '0;
		m_tdata[REM_LSB +: VAL_W]       = out_rem_q;
		m_tdata[STATUS_LSB +: STATUS_W] = out_status_q;
		m_tdata[COUNT_LSB +: COUNT_W]   = out_cnt_q;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("count above capacity");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == STATUS_FULL) |-> cnt_q == CW'(CAPACITY))
		else $error("full reported on a list that is not full");

	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && is_del_q && status_q == STATUS_OK) |-> next_cnt_q + CW'(1) == cnt_q)
		else $error("delete did not shrink the list by one");

	a_no_place_in_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.place && ins_ok_q) |-> !pend_s1 && left_q == '0)
		else $error("insert write while shift in flight");

endmodule

>>> rtl/indexed_list_insert_delete_core.sv
// Indexed list with insert and delete at a position, up to CAPACITY signed words.
// Input channel s_*: one transfer per operation. s_tdata holds, from bit 0 up,
// kind (2 bits: insert, delete, clear), position (7 bits), value (32 bits).
// Output channel m_*: exactly one transfer per operation. m_tdata holds, from
// bit 0 up, removed_value (32), status (2: ok, range, full), count (7).
// Entries live in a one-write, one-read RAM; insert and delete move the entries
// above the position one word per cycle through that RAM's ports.
// Each operation is loaded in the idle state, moves entries in the shift state and
// is committed from the finish state; clear, rejected or unused kind operations
// skip the shift state, and an insert at the end of the list passes it with no move.
// One operation is worked at a time; the next is taken once its result sits in
// the output register.
// When the receiver stalls, the result is held in the output register; a further
// operation is accepted and worked, then waits until that register frees.
// Reset empties the list (count zero) and clears the output channel's valid state;
// RAM contents are not cleared and are read only after being written.
module indexed_list_insert_delete_core #(
	parameter int CAPACITY = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ilist_pkg::TDATA_W-1:0] s_tdata,  // kind, position, value
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ilist_pkg::TDATA_W-1:0] m_tdata   // removed_value, status, count
);
	import ilist_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	ilist_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	ilist_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.cmd     (cmd),
		.stat    (stat)
	);

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
	import ilist_pkg::*;

	localparam int LIST_DEPTH = 64;
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} churn_mode_t;

	typedef struct {
		logic [VAL_W-1:0]    removed;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
	} list_result_t;

	class list_scoreboard;
		logic [VAL_W-1:0] entries [LIST_DEPTH];
		int unsigned      held;
		list_result_t     awaited_q [$];
		int unsigned      mismatches;

		function new();
			held = 0;
			mismatches = 0;
			foreach (entries[i]) entries[i] = '0;
		endfunction

		function int unsigned pending_count();
			return awaited_q.size();
		endfunction

		function void note_op(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
				logic [VAL_W-1:0] val);
			list_result_t res;
			res.removed = '0;
			res.status = STATUS_OK;
			if (kind == KIND_INSERT) begin
				if (pos > held) begin
					res.status = STATUS_RANGE;
				end else if (held >= LIST_DEPTH) begin
					res.status = STATUS_FULL;
				end else begin
					for (int i = held; i > pos; i--) entries[i] = entries[i-1];
					entries[pos] = val;
					held++;
				end
			end else if (kind == KIND_DELETE) begin
				if (pos >= held) begin
					res.status = STATUS_RANGE;
				end else begin
					res.removed = entries[pos];
					for (int i = pos; i + 1 < held; i++) entries[i] = entries[i+1];
					held--;
				end
			end else if (kind == KIND_CLEAR) begin
				held = 0;
			end
			res.count = held[COUNT_W-1:0];
			awaited_q.push_back(res);
		endfunction

		function void check_result(logic [TDATA_W-1:0] data);
			list_result_t exp_res;
			logic [VAL_W-1:0]    got_removed;
			logic [STATUS_W-1:0] got_status;
			logic [COUNT_W-1:0]  got_count;
			got_removed = data[REM_LSB +: VAL_W];
			got_status = data[STATUS_LSB +: STATUS_W];
			got_count = data[COUNT_LSB +: COUNT_W];
			if (awaited_q.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected result removed=%h status=%0d count=%0d",
						$time, got_removed, got_status, got_count);
				mismatches++;
				return;
			end
			exp_res = awaited_q.pop_front();
			if (got_removed !== exp_res.removed || got_status !== exp_res.status ||
					got_count !== exp_res.count) begin
				if (mismatches < 10)
					$display("%0t: mismatch exp removed=%h status=%0d count=%0d,",
						$time, exp_res.removed, exp_res.status, exp_res.count,
						" got removed=%h status=%0d count=%0d",
						got_removed, got_status, got_count);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata;   // kind, position, value, zero fill
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;   // removed_value, status, count, zero fill
	logic               no_idle;

	list_scoreboard sb = new();

	indexed_list_insert_delete_core #(.CAPACITY(LIST_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
			m_tready <= no_idle || ($urandom_range(0, 99) >= 36);
		end
	end

	function automatic logic [VAL_W-1:0] pick_word();
		case ($urandom_range(0, 19))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_op(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val);
		if (!no_idle) begin
			while ($urandom_range(0, 99) < 36) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'b0, val, pos, kind};
		do @(posedge clk); while (!s_tready);
		sb.note_op(kind, pos, val);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending_count() != 0) @(posedge clk);
	endtask

	task automatic churn_op(input churn_mode_t mode);
		int unsigned roll;
		int unsigned ins_limit;
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  pos;
		roll = $urandom_range(0, 99);
		case (mode)
			MODE_GROW:   ins_limit = 80;
			MODE_SHRINK: ins_limit = 27;
			default:     ins_limit = 56;
		endcase
		if (roll < 1) begin
			kind = KIND_CLEAR;
			pos = POS_W'($urandom_range(0, 64));
		end else if (roll < 2) begin
			kind = KIND_SPARE;
			pos = POS_W'($urandom_range(0, 64));
		end else if (roll < 11) begin
			kind = $urandom_range(0, 1) ? KIND_INSERT : KIND_DELETE;
			pos = POS_W'($urandom_range(0, 64));
		end else if (roll < ins_limit || sb.held == 0) begin
			kind = KIND_INSERT;
			pos = POS_W'($urandom_range(0, sb.held));
		end else begin
			kind = KIND_DELETE;
			pos = POS_W'($urandom_range(0, sb.held - 1));
		end
		send_op(kind, pos, pick_word());
	endtask

	initial begin
		int unsigned done;
		int unsigned span;
		churn_mode_t mode;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		no_idle = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(KIND_DELETE, 7'd0, 32'h0);
		send_op(KIND_DELETE, 7'd64, 32'h1);
		send_op(KIND_INSERT, 7'd1, 32'h2);
		send_op(KIND_INSERT, 7'd0, 32'h7fff_ffff);
		send_op(KIND_INSERT, 7'd1, 32'h8000_0000);
		send_op(KIND_INSERT, 7'd0, 32'hffff_ffff);
		send_op(KIND_INSERT, 7'd1, 32'h0);
		send_op(KIND_INSERT, 7'd64, 32'h1234_5678);
		send_op(KIND_SPARE, 7'd5, 32'hdead_beef);
		send_op(KIND_DELETE, 7'd1, 32'h0);
		send_op(KIND_DELETE, 7'd2, 32'h0);
		send_op(KIND_DELETE, 7'd0, 32'h0);
		send_op(KIND_DELETE, 7'd1, 32'h0);
		send_op(KIND_INSERT, 7'd1, 32'h5555_5555);
		send_op(KIND_INSERT, 7'd0, 32'haaaa_aaaa);
		send_op(KIND_CLEAR, 7'd63, 32'hffff_ffff);
		send_op(KIND_DELETE, 7'd0, 32'h0);
		send_op(KIND_SPARE, 7'd64, 32'h0);
		send_op(KIND_INSERT, 7'd0, 32'h1);
		send_op(KIND_DELETE, 7'd0, 32'h0);
		wait_drained();

		// fill to capacity, then push against the full list
		done = 0;
		while (sb.held < LIST_DEPTH) begin
			send_op(KIND_INSERT, POS_W'($urandom_range(0, sb.held)), pick_word());
			done++;
		end
		send_op(KIND_INSERT, 7'd0, pick_word());
		send_op(KIND_INSERT, 7'd64, pick_word());
		send_op(KIND_DELETE, 7'd64, pick_word());
		send_op(KIND_DELETE, 7'd63, pick_word());
		send_op(KIND_INSERT, 7'd63, pick_word());
		done += 5;

		while (done < 1130) begin
			mode = churn_mode_t'($urandom_range(0, 2));
			span = $urandom_range(20, 120);
			repeat (span) begin
				no_idle = (done >= 450 && done < 700);
				churn_op(mode);
				done++;
			end
			if ($urandom_range(0, 3) == 0) wait_drained();
		end
		no_idle = 1'b0;

		wait_drained();
		repeat (80) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_count() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
